// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules, used by seen_address_table_with_aging
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while reset is active
`define SAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising edge of clk, reset included
`define SAT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sat_pkg.sv =====
// Types and constants of the seen-address table
package sat_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 48;
    localparam int TIME_W        = 48;
    localparam int TIMEOUT_W     = 32;
    localparam int COUNT_W       = 6;
    localparam int APB_ADDR_W    = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd20000;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 6'd63;
    localparam logic                 REG_TIMEOUT   = 1'b0;
    localparam logic                 MODE_LOOKUP   = 1'b0;
    localparam logic                 MODE_SWEEP    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } sat_state_t;

    typedef struct packed {
        logic match;
        logic expire;
    } cmp_res_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic scan_en;
    } ctrl_t;

endpackage

// ===== hw/rtl/sat_cmp.sv =====
// Shared subtract-and-compare unit for address match and age check
module sat_cmp (
    input  logic                          mode,
    input  logic [sat_pkg::ADDR_W-1:0]    key,
    input  logic [sat_pkg::TIME_W-1:0]    now,
    input  logic [sat_pkg::ADDR_W-1:0]    entry_addr,
    input  logic [sat_pkg::TIME_W-1:0]    entry_time,
    input  logic [sat_pkg::TIMEOUT_W-1:0] timeout,
    output sat_pkg::cmp_res_t             res
);
    import sat_pkg::*;

    logic [ADDR_W-1:0] op_a;
    logic [ADDR_W-1:0] op_b;
    logic [ADDR_W:0]   diff;

    assign op_a = (mode == MODE_SWEEP) ? now : key;
    assign op_b = (mode == MODE_SWEEP) ? entry_time : entry_addr;
    assign diff = {1'b0, op_a} - {1'b0, op_b};

    always_comb
    begin
        res.match  = (diff == '0);
        res.expire = !diff[ADDR_W] && (diff != '0) &&
                     (diff[ADDR_W-1:0] > {{(ADDR_W-TIMEOUT_W){1'b0}}, timeout});
    end

endmodule

// ===== hw/rtl/seen_address_table_with_aging.sv =====
// Seen-address table with aging: sequencer, entry memories and APB register
// A start transfer runs the sequencer through ST_SCAN, ST_DRAIN and ST_DONE; done strobes in ST_DONE.
// No new item is taken while busy; the scan reads one entry per cycle
// from the single read port of the address and time memories.
// Reset clears all valid bits at once and loads timeout_ms with 20000; no clearing pass.
// Results last one cycle on done; the receiver cannot stall.
`include "assert_macros.svh"

module seen_address_table_with_aging (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic [sat_pkg::ADDR_W-1:0]         device_address,
    input  logic [sat_pkg::TIME_W-1:0]         now_time,
    output logic                               done,
    output logic                               already_seen,
    output logic                               inserted,
    output logic                               table_full,
    output logic [sat_pkg::COUNT_W-1:0]        expired_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sat_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import sat_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    sat_state_t              state_reg, state_next;
    ctrl_t                   ctrl;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic                    mode_reg;
    logic [ADDR_W-1:0]       key_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    cmp_vld_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                    hit_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic [TIME_W-1:0]       rd_time_reg;
    logic [ADDR_W-1:0]       entry_address [TABLE_ENTRIES];
    logic [TIME_W-1:0]       entry_time    [TABLE_ENTRIES];
    cmp_res_t                cmp_res;
    logic                    accept;
    logic                    cfg_write;
    logic                    cmp_valid_entry;
    logic                    do_insert;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write && paddr[2] == REG_TIMEOUT)
        begin
            timeout_reg <= pwdata;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SCAN;
            ST_SCAN:  if (scan_idx_reg == LAST_IDX) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:  ctrl = '0;
            ST_SCAN:  begin ctrl.busy = 1'b1; ctrl.scan_en = 1'b1; end
            ST_DRAIN: ctrl.busy = 1'b1;
            ST_DONE:  begin ctrl.busy = 1'b1; ctrl.done = 1'b1; end
            default:  ctrl = '0;
        endcase
    end

    assign busy = ctrl.busy;
    assign done = ctrl.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= ctrl.scan_en;
            if (accept)
            begin
                scan_idx_reg <= '0;
            end
            else if (ctrl.scan_en)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            key_reg  <= device_address;
            now_reg  <= now_time;
        end
        if (ctrl.scan_en)
        begin
            cmp_idx_reg <= scan_idx_reg;
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            entry_address[free_idx_reg] <= key_reg;
            entry_time[free_idx_reg]    <= now_reg;
        end
        rd_addr_reg <= entry_address[scan_idx_reg];
        rd_time_reg <= entry_time[scan_idx_reg];
    end

    sat_cmp u_cmp (
        .mode       (mode_reg),
        .key        (key_reg),
        .now        (now_reg),
        .entry_addr (rd_addr_reg),
        .entry_time (rd_time_reg),
        .timeout    (timeout_reg),
        .res        (cmp_res)
    );

    assign cmp_valid_entry = valid_reg[cmp_idx_reg];
    assign do_insert       = ctrl.done && (mode_reg == MODE_LOOKUP) &&
                             !hit_reg && free_found_reg;

    // scan results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (cmp_vld_reg)
        begin
            if (mode_reg == MODE_SWEEP)
            begin
                if (cmp_valid_entry && cmp_res.expire)
                begin
                    valid_reg[cmp_idx_reg] <= 1'b0;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
            else
            begin
                if (cmp_valid_entry && cmp_res.match)
                begin
                    hit_reg <= 1'b1;
                end
                if (!cmp_valid_entry && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
        end
        else if (do_insert)
        begin
            valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    assign already_seen  = (mode_reg == MODE_LOOKUP) && hit_reg;
    assign inserted      = (mode_reg == MODE_LOOKUP) && !hit_reg && free_found_reg;
    assign table_full    = (mode_reg == MODE_LOOKUP) && !hit_reg && !free_found_reg;
    assign expired_count = (mode_reg == MODE_SWEEP) ? count_reg : '0;

    `SAT_ASSERT(a_accept_busy, accept |=> busy, "start transfer did not make the block busy")
    `SAT_ASSERT(a_lookup_onehot, done && mode_reg == MODE_LOOKUP |-> $onehot({already_seen, inserted, table_full}), "lookup result flags not one-hot")
    `SAT_ASSERT(a_insert_grows, done && inserted |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1, "insert did not add one valid entry")
    `SAT_ASSERT_ALWAYS(a_done_busy, done |-> busy, "result strobe outside a busy item")

endmodule

// ===== bench/tb_seen_address_table_with_aging.sv =====
// Testbench for the seen-address table with aging: random and directed lookups and sweeps
module tb_seen_address_table_with_aging;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = APB_ADDR_W'(4 * REG_TIMEOUT);
    localparam logic [ADDR_W-1:0]     ADDR_ONES    = '1;
    localparam logic [TIME_W-1:0]     TIME_ONES    = '1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
    } command_t;

    typedef struct packed {
        logic               already_seen;
        logic               inserted;
        logic               table_full;
        logic [COUNT_W-1:0] expired_count;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  mode = MODE_LOOKUP;
    logic [ADDR_W-1:0]     device_address = '0;
    logic [TIME_W-1:0]     now_time = '0;
    logic                  done;
    logic                  already_seen;
    logic                  inserted;
    logic                  table_full;
    logic [COUNT_W-1:0]    expired_count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    command_t            commands_pending[$];
    verdict_t            verdicts_due[$];
    command_t            offer;
    logic                offer_held = 1'b0;
    int                  idle_level = 26;
    int                  errors = 0;
    logic [TIME_W-1:0]   clock_ms = '0;

    logic [ADDR_W-1:0]    slot_addr[TABLE_ENTRIES];
    logic [TIME_W-1:0]    slot_stamp[TABLE_ENTRIES];
    logic                 slot_live[TABLE_ENTRIES];
    logic [TIMEOUT_W-1:0] timeout_model = TIMEOUT_RESET;

    seen_address_table_with_aging u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .device_address (device_address),
        .now_time       (now_time),
        .done           (done),
        .already_seen   (already_seen),
        .inserted       (inserted),
        .table_full     (table_full),
        .expired_count  (expired_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic verdict_t table_update(input command_t c);
        verdict_t v;
        logic     placed;
        v = '0;
        placed = 1'b0;
        if (c.mode == MODE_SWEEP)
        begin
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                if (slot_live[k] && c.stamp > slot_stamp[k] &&
                    (c.stamp - slot_stamp[k]) > {16'd0, timeout_model})
                begin
                    slot_live[k] = 1'b0;
                    if (v.expired_count != COUNT_MAX)
                        v.expired_count++;
                end
            end
        end
        else
        begin
            for (int k = 0; k < TABLE_ENTRIES; k++)
                if (slot_live[k] && slot_addr[k] == c.addr)
                    v.already_seen = 1'b1;
            if (!v.already_seen)
            begin
                for (int k = 0; k < TABLE_ENTRIES; k++)
                begin
                    if (!placed && !slot_live[k])
                    begin
                        slot_live[k]  = 1'b1;
                        slot_addr[k]  = c.addr;
                        slot_stamp[k] = c.stamp;
                        placed = 1'b1;
                    end
                end
                v.inserted   = placed;
                v.table_full = !placed;
            end
        end
        return v;
    endfunction

    always @(posedge clk)
    begin
        logic offered;
        offered = offer_held;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                verdicts_due.push_back(table_update(offer));
                offered = 1'b0;
            end
            if (!offered && commands_pending.size() > 0)
            begin
                offer = commands_pending.pop_front();
                mode <= offer.mode;
                device_address <= offer.addr;
                now_time <= offer.stamp;
                offered = 1'b1;
            end
            offer_held = offered;
            start <= offered && ($urandom_range(99) >= idle_level);
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            if (verdicts_due.size() == 0)
                flag_mismatch("result with no transfer outstanding");
            else
            begin
                want = verdicts_due.pop_front();
                if (already_seen !== want.already_seen)
                    flag_mismatch($sformatf("already_seen %b, want %b",
                                            already_seen, want.already_seen));
                if (inserted !== want.inserted)
                    flag_mismatch($sformatf("inserted %b, want %b", inserted, want.inserted));
                if (table_full !== want.table_full)
                    flag_mismatch($sformatf("table_full %b, want %b",
                                            table_full, want.table_full));
                if (expired_count !== want.expired_count)
                    flag_mismatch($sformatf("expired_count %0d, want %0d",
                                            expired_count, want.expired_count));
            end
        end
    end

    function automatic logic [47:0] rand48();
        logic [47:0] r;
        r[31:0]  = $urandom;
        r[47:32] = 16'($urandom);
        return r;
    endfunction

    task automatic wait_quiet();
        do @(negedge clk);
        while (commands_pending.size() != 0 || offer_held || verdicts_due.size() != 0 || busy);
    endtask

    task automatic read_timeout(input logic [31:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= TIMEOUT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (!pready);
        if (prdata !== want)
            flag_mismatch($sformatf("timeout_ms read %h, want %h", prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timeout(input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TIMEOUT_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (!pready);
        timeout_model = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        read_timeout(value);
    endtask

    task automatic push_command(input logic m, input logic [47:0] a, input logic [47:0] t);
        command_t c;
        c.mode  = m;
        c.addr  = a;
        c.stamp = t;
        commands_pending.push_back(c);
    endtask

    task automatic run_phase(input logic [31:0] tmo, input int n, input int pool_n,
                             input logic [31:0] stride, input int idle);
        logic [ADDR_W-1:0] pool[$];
        int                r;
        set_timeout(tmo);
        idle_level = idle;
        for (int k = 0; k < pool_n; k++)
            pool.push_back(rand48());
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            clock_ms += 48'($urandom_range(0, stride));
            if (r < 4)
                clock_ms -= 48'($urandom_range(0, stride));
            else if (r < 6)
                clock_ms = rand48();
            push_command(($urandom_range(99) < 15) ? MODE_SWEEP : MODE_LOOKUP,
                         ($urandom_range(99) < 88) ? pool[$urandom_range(0, pool_n - 1)]
                                                   : rand48(),
                         clock_ms);
        end
        wait_quiet();
    endtask

    initial
    begin
        logic [31:0] tmo;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            slot_addr[k]  = '0;
            slot_stamp[k] = '0;
            slot_live[k]  = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        read_timeout(TIMEOUT_RESET);
        @(negedge clk);

        push_command(MODE_LOOKUP, '0, '0);
        push_command(MODE_LOOKUP, '0, 48'd5);
        push_command(MODE_LOOKUP, ADDR_ONES, TIME_ONES);
        push_command(MODE_LOOKUP, ADDR_ONES, '0);
        push_command(MODE_LOOKUP, 48'd1, 48'd10);
        push_command(MODE_LOOKUP, 48'h8000_0000_0000, 48'd10);
        push_command(MODE_SWEEP, ADDR_ONES, 48'd20000);
        push_command(MODE_SWEEP, '0, 48'd20010);
        push_command(MODE_SWEEP, 48'h5555_5555_5555, 48'd20011);
        push_command(MODE_SWEEP, 48'hAAAA_AAAA_AAAA, '0);
        push_command(MODE_LOOKUP, '0, 48'd20011);
        push_command(MODE_LOOKUP, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
        push_command(MODE_LOOKUP, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        push_command(MODE_SWEEP, ADDR_ONES, TIME_ONES);
        push_command(MODE_LOOKUP, ADDR_ONES, 48'd7);
        push_command(MODE_SWEEP, '0, TIME_ONES);
        wait_quiet();

        clock_ms = 48'd1000;
        run_phase('0, 150, 20, 32'd2, 26);
        run_phase('1, 150, 40, 32'h4000_0000, 26);
        run_phase(TIMEOUT_RESET, 200, 36, 32'd600, 0);
        for (int p = 0; p < 4; p++)
        begin
            tmo = $urandom;
            run_phase(tmo, 200, $urandom_range(4, 60), (tmo >> $urandom_range(0, 8)) | 32'd1,
                      26);
        end

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
